// File: rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define CLA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked in every cycle, reset included.
`define CLA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/cla_pkg.sv
`timescale 1ns / 1ps
// Types, codes and helpers shared by the control lease arbiter.
package cla_pkg;

  localparam int IN_TDATA_W  = 168;
  localparam int OUT_TDATA_W = 120;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [2:0] ACT_CLAIM   = 3'd0;
  localparam logic [2:0] ACT_PREEMPT = 3'd1;
  localparam logic [2:0] ACT_RENEW   = 3'd2;
  localparam logic [2:0] ACT_RELEASE = 3'd3;
  localparam logic [2:0] ACT_QUERY   = 3'd4;

  localparam logic [2:0] SRC_UNKNOWN = 3'd0;

  localparam logic KIND_REPLY  = 1'b0;
  localparam logic KIND_REVOKE = 1'b1;

  localparam logic [2:0] LS_NONE     = 3'd0;
  localparam logic [2:0] LS_CTRL     = 3'd1;
  localparam logic [2:0] LS_REJECTED = 3'd2;
  localparam logic [2:0] LS_RELEASED = 3'd3;
  localparam logic [2:0] LS_REVOKED  = 3'd4;

  localparam logic [1:0] RSN_OK       = 2'd0;
  localparam logic [1:0] RSN_REJECTED = 2'd1;
  localparam logic [1:0] RSN_TIMEOUT  = 2'd2;

  localparam logic [3:0] DET_GRANTED    = 4'd0;
  localparam logic [3:0] DET_RENEWED    = 4'd1;
  localparam logic [3:0] DET_RELEASED   = 4'd2;
  localparam logic [3:0] DET_NOT_HOLDER = 4'd3;
  localparam logic [3:0] DET_HELD       = 4'd4;
  localparam logic [3:0] DET_BAD_SOURCE = 4'd5;
  localparam logic [3:0] DET_NO_SESSION = 4'd6;
  localparam logic [3:0] DET_EXPIRED    = 4'd7;
  localparam logic [3:0] DET_PREEMPTED  = 4'd8;
  localparam logic [3:0] DET_QUERY      = 4'd9;

  typedef struct packed {
    logic        notice_kind;
    logic [2:0]  lease_state;
    logic [1:0]  reason;
    logic [3:0]  detail;
    logic [63:0] out_session;
    logic [31:0] out_ttl_ms;
    logic [7:0]  out_peer;
    logic [2:0]  out_source;
    logic        last;
  } cla_result_t;

  typedef struct packed {
    logic [1:0]  count;
    cla_result_t first;
    cla_result_t second;
  } cla_push_t;

  function automatic cla_result_t make_result(
    input logic        kind,
    input logic [2:0]  st,
    input logic [1:0]  rsn,
    input logic [3:0]  det,
    input logic [63:0] sess,
    input logic [31:0] ttl,
    input logic [7:0]  peer,
    input logic [2:0]  src,
    input logic        last
  );
    cla_result_t r;
    r.notice_kind = kind;
    r.lease_state = st;
    r.reason      = rsn;
    r.detail      = det;
    r.out_session = sess;
    r.out_ttl_ms  = ttl;
    r.out_peer    = peer;
    r.out_source  = src;
    r.last        = last;
    return r;
  endfunction

endpackage

// File: rtl/core/control_lease_arbiter.sv
`timescale 1ns / 1ps
// Control lease arbiter top level: request decode, lease decision, table update.
//
// Requests enter on the s_ stream; each transaction carries one request for one
// lease slot. Results leave on the m_ stream: an optional revoke notice to the
// previous holder (m_tuser = 1, m_tlast = 0) followed by the reply to the
// requester (m_tuser = 0, m_tlast = 1).
// The accept edge reads the slot from the lease RAM and enters ST_DECIDE,
// which decides; the next edge writes the slot back and queues the results.
// s_tready is low in ST_DECIDE, so one request is in flight at a time and a
// new request is not taken until the last one has been decided.
// Results are written into a four-entry queue and shown on m_ from its head;
// a stalled m_tready holds them there, and outside ST_DECIDE s_tready drops
// only once fewer than two queue entries are free.
// Reset clears all held flags, so every slot starts free; the lease RAM keeps
// no reset and its contents are only used for slots whose held flag is set.
// target_index is reduced modulo TARGET_SLOTS; PEER_BITS sets the stored and
// compared width of the peer identifier.
module control_lease_arbiter #(
  parameter int TARGET_SLOTS = 16,
  parameter int PEER_BITS    = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // target_index[3:0], peer_index[11:4], session[75:12],
  // control_source[78:76], ttl_ms[110:79], preempt_ok[111],
  // session_active[112], now_ms[160:113], zero pad[167:161]
  input  logic [cla_pkg::IN_TDATA_W-1:0] s_tdata,
  // action[2:0]
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // lease_state[2:0], reason[4:3], detail[8:5], out_session[72:9],
  // out_ttl_ms[104:73], out_peer[112:105], out_source[115:113], zero pad[119:116]
  output logic [cla_pkg::OUT_TDATA_W-1:0] m_tdata,
  // notice_kind[0]
  output logic [0:0]   m_tuser,
  output logic         m_tlast
);

  localparam int USED    = TARGET_SLOTS < 16 ? TARGET_SLOTS : 16;
  localparam int SW      = USED > 1 ? $clog2(USED) : 1;
  localparam int PEER_LO = 83;
  localparam int SESS_LO = PEER_LO + PEER_BITS;
  localparam int EW      = SESS_LO + 64;

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_DECIDE = 1'b1;

  logic state;
  logic accept;

  logic [SW-1:0] slot_lut [16];
  for (genvar g = 0; g < 16; g++) begin : g_slot
    assign slot_lut[g] = SW'(g % USED);
  end

  logic [15:0]          in_peer_wide;
  logic [48:0]          exp_sum;
  logic [2:0]           req_act;
  logic [SW-1:0]        req_slot;
  logic [PEER_BITS-1:0] req_peer;
  logic [63:0]          req_sess;
  logic [2:0]           req_src;
  logic [31:0]          req_ttl;
  logic                 req_pre;
  logic                 req_active;
  logic [47:0]          req_now;
  logic [47:0]          req_exp;

  logic [EW-1:0]        rd;
  logic                 mem_we;
  logic [EW-1:0]        mem_wdata;
  logic [USED-1:0]      held_bits;
  logic                 held_set;
  logic                 held_clr;

  logic [63:0]          h_sess;
  logic [PEER_BITS-1:0] h_peer;
  logic [15:0]          h_peer_wide;
  logic [7:0]           h_peer8;
  logic [2:0]           h_src;
  logic [31:0]          h_ttl;
  logic [47:0]          h_exp;
  logic                 held;
  logic                 expired;
  logic                 held_live;
  logic                 same;

  cla_pkg::cla_push_t   push;
  cla_pkg::cla_result_t head;
  logic                 room;

  assign accept       = s_tvalid && s_tready;
  assign s_tready     = (state == ST_IDLE) && room;
  assign in_peer_wide = {8'b0, s_tdata[11:4]};
  assign exp_sum      = {1'b0, s_tdata[160:113]} + 49'(s_tdata[110:79]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE:   if (accept) state <= ST_DECIDE;
        ST_DECIDE: state <= ST_IDLE;
        default:   state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_act    <= s_tuser;
      req_slot   <= slot_lut[s_tdata[3:0]];
      req_peer   <= in_peer_wide[PEER_BITS-1:0];
      req_sess   <= s_tdata[75:12];
      req_src    <= s_tdata[78:76];
      req_ttl    <= s_tdata[110:79];
      req_pre    <= s_tdata[111];
      req_active <= s_tdata[112];
      req_now    <= s_tdata[160:113];
      req_exp    <= exp_sum[48] ? '1 : exp_sum[47:0];
    end
  end

  cla_mem #(
    .DEPTH (USED),
    .WIDTH (EW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (req_slot),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (slot_lut[s_tdata[3:0]]),
    .rdata (rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_bits <= '0;
    end else if (held_set) begin
      held_bits[req_slot] <= 1'b1;
    end else if (held_clr) begin
      held_bits[req_slot] <= 1'b0;
    end
  end

  assign h_exp       = rd[47:0];
  assign h_ttl       = rd[79:48];
  assign h_src       = rd[82:80];
  assign h_peer      = rd[SESS_LO-1:PEER_LO];
  assign h_sess      = rd[EW-1:SESS_LO];
  assign h_peer_wide = 16'(h_peer);
  assign h_peer8     = h_peer_wide[7:0];
  assign held        = held_bits[req_slot];
  assign expired     = held && (h_exp != '0) && (h_exp < req_now);
  assign held_live   = held && !expired;
  assign same        = held_live && (h_sess == req_sess) && (h_peer == req_peer);

  always_comb begin
    cla_pkg::cla_result_t rev;
    cla_pkg::cla_result_t rep;
    logic has_rev;
    rev       = '0;
    rep       = '0;
    has_rev   = 1'b0;
    push      = '0;
    mem_we    = 1'b0;
    mem_wdata = {req_sess, req_peer, req_src, req_ttl, req_exp};
    held_set  = 1'b0;
    held_clr  = 1'b0;
    if (state == ST_DECIDE) begin
      push.count = 2'd1;
      if (req_act >= cla_pkg::ACT_QUERY) begin
        if (held_live) begin
          push.first = cla_pkg::make_result(cla_pkg::KIND_REPLY, cla_pkg::LS_CTRL,
            cla_pkg::RSN_OK, cla_pkg::DET_QUERY, h_sess, h_ttl, h_peer8, h_src, 1'b1);
        end else begin
          push.first = cla_pkg::make_result(cla_pkg::KIND_REPLY, cla_pkg::LS_NONE,
            cla_pkg::RSN_OK, cla_pkg::DET_QUERY, '0, '0, '0, '0, 1'b1);
        end
      end else if (req_src == cla_pkg::SRC_UNKNOWN) begin
        push.first = cla_pkg::make_result(cla_pkg::KIND_REPLY, cla_pkg::LS_REJECTED,
          cla_pkg::RSN_REJECTED, cla_pkg::DET_BAD_SOURCE, req_sess, req_ttl, '0, '0, 1'b1);
      end else if (!req_active) begin
        push.first = cla_pkg::make_result(cla_pkg::KIND_REPLY, cla_pkg::LS_REJECTED,
          cla_pkg::RSN_REJECTED, cla_pkg::DET_NO_SESSION, req_sess, req_ttl, '0, '0, 1'b1);
      end else begin
        if (expired) begin
          has_rev  = 1'b1;
          held_clr = 1'b1;
          rev = cla_pkg::make_result(cla_pkg::KIND_REVOKE, cla_pkg::LS_REVOKED,
            cla_pkg::RSN_TIMEOUT, cla_pkg::DET_EXPIRED, h_sess, h_ttl, h_peer8, '0, 1'b0);
        end
        priority if (req_act == cla_pkg::ACT_RELEASE) begin
          if (same) begin
            held_clr = 1'b1;
            rep = cla_pkg::make_result(cla_pkg::KIND_REPLY, cla_pkg::LS_RELEASED,
              cla_pkg::RSN_OK, cla_pkg::DET_RELEASED, req_sess, '0, '0, '0, 1'b1);
          end else begin
            rep = cla_pkg::make_result(cla_pkg::KIND_REPLY, cla_pkg::LS_REJECTED,
              cla_pkg::RSN_REJECTED, cla_pkg::DET_NOT_HOLDER, req_sess, '0, '0, '0, 1'b1);
          end
        end else if (req_act == cla_pkg::ACT_RENEW) begin
          if (same) begin
            mem_we    = 1'b1;
            mem_wdata = {rd[EW-1:80], req_ttl, req_exp};
            rep = cla_pkg::make_result(cla_pkg::KIND_REPLY, cla_pkg::LS_CTRL,
              cla_pkg::RSN_OK, cla_pkg::DET_RENEWED, req_sess, req_ttl, '0, '0, 1'b1);
          end else begin
            rep = cla_pkg::make_result(cla_pkg::KIND_REPLY, cla_pkg::LS_REJECTED,
              cla_pkg::RSN_REJECTED, cla_pkg::DET_NOT_HOLDER, req_sess, req_ttl, '0, '0,
              1'b1);
          end
        end else if (!held_live || same || req_pre ||
                     req_act == cla_pkg::ACT_PREEMPT) begin
          if (held_live && !same) begin
            has_rev = 1'b1;
            rev = cla_pkg::make_result(cla_pkg::KIND_REVOKE, cla_pkg::LS_REVOKED,
              cla_pkg::RSN_REJECTED, cla_pkg::DET_PREEMPTED, h_sess, h_ttl, h_peer8, '0,
              1'b0);
          end
          mem_we   = 1'b1;
          held_set = 1'b1;
          rep = cla_pkg::make_result(cla_pkg::KIND_REPLY, cla_pkg::LS_CTRL,
            cla_pkg::RSN_OK, cla_pkg::DET_GRANTED, req_sess, req_ttl, '0, '0, 1'b1);
        end else begin
          rep = cla_pkg::make_result(cla_pkg::KIND_REPLY, cla_pkg::LS_REJECTED,
            cla_pkg::RSN_REJECTED, cla_pkg::DET_HELD, req_sess, req_ttl, '0, '0, 1'b1);
        end
        if (has_rev) begin
          push.count  = 2'd2;
          push.first  = rev;
          push.second = rep;
        end else begin
          push.first  = rep;
        end
      end
    end
  end

  cla_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .room  (room),
    .valid (m_tvalid),
    .ready (m_tready),
    .head  (head)
  );

  assign m_tdata = {4'b0, head.out_source, head.out_peer, head.out_ttl_ms,
                    head.out_session, head.detail, head.reason, head.lease_state};
  assign m_tuser = head.notice_kind;
  assign m_tlast = head.last;

endmodule

// File: rtl/core/cla_mem.sv
`timescale 1ns / 1ps
// Lease table RAM: one write port, one read port with registered read data.
module cla_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 155
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/cla_outq.sv
`timescale 1ns / 1ps
// Result queue: takes one or two results per cycle, drains one per transaction.
module cla_outq (
  input  logic                 clk,
  input  logic                 rst,
  input  cla_pkg::cla_push_t   push,
  output logic                 room,
  output logic                 valid,
  input  logic                 ready,
  output cla_pkg::cla_result_t head
);

  cla_pkg::cla_result_t q [cla_pkg::QDEPTH];
  logic [cla_pkg::QPTR_W-1:0] wp;
  logic [cla_pkg::QPTR_W-1:0] rp;
  logic [cla_pkg::QCNT_W-1:0] count;
  logic [cla_pkg::QPTR_W-1:0] wp_plus1;
  logic pop;

  assign pop      = valid && ready;
  assign valid    = count != '0;
  assign head     = q[rp];
  assign room     = count <= cla_pkg::QCNT_W'(cla_pkg::QDEPTH - 2);
  assign wp_plus1 = wp + 1'b1;

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      q[wp] <= push.first;
    end
    if (push.count == 2'd2) begin
      q[wp_plus1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + cla_pkg::QPTR_W'(push.count);
      rp    <= rp + cla_pkg::QPTR_W'(pop);
      count <= count + cla_pkg::QCNT_W'(push.count) - cla_pkg::QCNT_W'(pop);
    end
  end

endmodule

// File: rtl/core/cla_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the control lease arbiter, bound to the top level.
`include "assert_macros.svh"

module cla_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [0:0] m_tuser,
  input logic       m_tlast
);

  `CLA_ASSERT_ALWAYS(a_empty_after_reset, rst |=> !m_tvalid, "result valid after reset")
  `CLA_ASSERT(a_one_in_flight, s_tvalid && s_tready |=> !s_tready, "request taken back to back")
  `CLA_ASSERT(a_revoke_not_last, m_tvalid && m_tuser[0] |-> !m_tlast, "revoke notice marked last")
  `CLA_ASSERT(a_reply_last, m_tvalid && !m_tuser[0] |-> m_tlast, "reply not marked last")
  `CLA_ASSERT(a_hold_stalled, m_tvalid && !m_tready |=> m_tvalid, "stalled result dropped")

endmodule

bind control_lease_arbiter cla_checker u_cla_checker (.*);

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking control lease arbiter bench: directed and random traffic against a predictor.
module testbench;
  import cla_pkg::*;

  localparam int SLOTS = 16;

  typedef struct {
    logic [2:0]  action;
    logic [3:0]  slot;
    logic [7:0]  peer;
    logic [63:0] session;
    logic [2:0]  source;
    logic [31:0] ttl;
    logic        preempt;
    logic        active;
    logic [47:0] now;
    bit          drain_first;
  } lease_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic [2:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [0:0] m_tuser;
  logic m_tlast;

  lease_req_t request_q[$];
  cla_result_t status_q[$];
  lease_req_t inflight;
  int mismatches = 0;
  int send_gap = 0;
  int recv_stall = 0;

  // lease table as the predictor sees it
  logic        lease_held [SLOTS] = '{default: 1'b0};
  logic [63:0] lease_sess [SLOTS];
  logic [7:0]  lease_peer [SLOTS];
  logic [2:0]  lease_src  [SLOTS];
  logic [31:0] lease_ttl  [SLOTS];
  logic [47:0] lease_exp  [SLOTS];

  control_lease_arbiter DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #10 clk = ~clk;

  function automatic logic lease_live(int unsigned s, logic [47:0] t);
    return lease_held[s] && !(lease_exp[s] != '0 && lease_exp[s] < t);
  endfunction

  function automatic void queue_status(logic kind, logic [2:0] st, logic [1:0] rsn,
                                       logic [3:0] det, logic [63:0] sess,
                                       logic [31:0] ttl, logic [7:0] peer,
                                       logic [2:0] src, logic fin);
    cla_result_t r;
    r.notice_kind = kind;
    r.lease_state = st;
    r.reason      = rsn;
    r.detail      = det;
    r.out_session = sess;
    r.out_ttl_ms  = ttl;
    r.out_peer    = peer;
    r.out_source  = src;
    r.last        = fin;
    status_q.insert(status_q.size(), r);
  endfunction

  function automatic void predict_lease_status(lease_req_t r);
    int unsigned s;
    logic [48:0] sum;
    logic [47:0] new_exp;
    logic same;
    logic may_take;
    s = r.slot % SLOTS;
    if (r.action >= ACT_QUERY) begin
      if (lease_live(s, r.now))
        queue_status(KIND_REPLY, LS_CTRL, RSN_OK, DET_QUERY, lease_sess[s], lease_ttl[s],
                     lease_peer[s], lease_src[s], 1'b1);
      else
        queue_status(KIND_REPLY, LS_NONE, RSN_OK, DET_QUERY, '0, '0, '0, '0, 1'b1);
    end else if (r.source == SRC_UNKNOWN) begin
      queue_status(KIND_REPLY, LS_REJECTED, RSN_REJECTED, DET_BAD_SOURCE, r.session, r.ttl,
                   '0, '0, 1'b1);
    end else if (!r.active) begin
      queue_status(KIND_REPLY, LS_REJECTED, RSN_REJECTED, DET_NO_SESSION, r.session, r.ttl,
                   '0, '0, 1'b1);
    end else begin
      if (lease_held[s] && !lease_live(s, r.now)) begin
        queue_status(KIND_REVOKE, LS_REVOKED, RSN_TIMEOUT, DET_EXPIRED, lease_sess[s],
                     lease_ttl[s], lease_peer[s], '0, 1'b0);
        lease_held[s] = 1'b0;
      end
      sum = {1'b0, r.now} + r.ttl;
      new_exp = sum[48] ? '1 : sum[47:0];
      same = lease_held[s] && lease_sess[s] == r.session && lease_peer[s] == r.peer;
      may_take = r.action == ACT_PREEMPT || r.preempt;
      case (r.action)
        ACT_RELEASE: begin
          if (same) begin
            lease_held[s] = 1'b0;
            queue_status(KIND_REPLY, LS_RELEASED, RSN_OK, DET_RELEASED, r.session, '0, '0,
                         '0, 1'b1);
          end else begin
            queue_status(KIND_REPLY, LS_REJECTED, RSN_REJECTED, DET_NOT_HOLDER, r.session,
                         '0, '0, '0, 1'b1);
          end
        end
        ACT_RENEW: begin
          if (same) begin
            lease_ttl[s] = r.ttl;
            lease_exp[s] = new_exp;
            queue_status(KIND_REPLY, LS_CTRL, RSN_OK, DET_RENEWED, r.session, r.ttl, '0,
                         '0, 1'b1);
          end else begin
            queue_status(KIND_REPLY, LS_REJECTED, RSN_REJECTED, DET_NOT_HOLDER, r.session,
                         r.ttl, '0, '0, 1'b1);
          end
        end
        default: begin
          if (!lease_held[s] || same || may_take) begin
            if (lease_held[s] && !same)
              queue_status(KIND_REVOKE, LS_REVOKED, RSN_REJECTED, DET_PREEMPTED,
                           lease_sess[s], lease_ttl[s], lease_peer[s], '0, 1'b0);
            lease_held[s] = 1'b1;
            lease_sess[s] = r.session;
            lease_peer[s] = r.peer;
            lease_src[s]  = r.source;
            lease_ttl[s]  = r.ttl;
            lease_exp[s]  = new_exp;
            queue_status(KIND_REPLY, LS_CTRL, RSN_OK, DET_GRANTED, r.session, r.ttl, '0,
                         '0, 1'b1);
          end else begin
            queue_status(KIND_REPLY, LS_REJECTED, RSN_REJECTED, DET_HELD, r.session, r.ttl,
                         '0, '0, 1'b1);
          end
        end
      endcase
    end
  endfunction

  function automatic void add_request(logic [2:0] act, logic [3:0] slot, logic [7:0] peer,
                                      logic [63:0] sess, logic [2:0] src, logic [31:0] ttl,
                                      logic pre, logic active, logic [47:0] now, bit drain);
    lease_req_t r;
    r.action      = act;
    r.slot        = slot;
    r.peer        = peer;
    r.session     = sess;
    r.source      = src;
    r.ttl         = ttl;
    r.preempt     = pre;
    r.active      = active;
    r.now         = now;
    r.drain_first = drain;
    request_q.insert(request_q.size(), r);
  endfunction

  // no idling near the end, and in every fourth stretch of 150 requests
  function automatic bit no_idle();
    return request_q.size() < 120 || (request_q.size() / 150) % 4 == 1;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s expected %0h got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : drive_requests
    logic fire;
    logic present;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      fire = s_tvalid && s_tready;
      present = s_tvalid && !fire;
      if (fire)
        predict_lease_status(inflight);
      if (!present) begin
        if (send_gap == 0 && !no_idle() && $urandom_range(0, 6) == 0)
          send_gap = $urandom_range(1, 13);
        if (send_gap > 0) begin
          send_gap--;
        end else if (request_q.size() > 0 &&
                     !(request_q[0].drain_first && status_q.size() > 0)) begin
          inflight = request_q.pop_front();
          present = 1'b1;
          s_tdata <= {7'd0, inflight.now, inflight.active, inflight.preempt, inflight.ttl,
                      inflight.source, inflight.session, inflight.peer, inflight.slot};
          s_tuser <= inflight.action;
        end
      end
      s_tvalid <= present;
    end
  end

  always @(posedge clk) begin : watch_results
    cla_result_t got;
    cla_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.notice_kind = m_tuser[0];
        got.lease_state = m_tdata[2:0];
        got.reason      = m_tdata[4:3];
        got.detail      = m_tdata[8:5];
        got.out_session = m_tdata[72:9];
        got.out_ttl_ms  = m_tdata[104:73];
        got.out_peer    = m_tdata[112:105];
        got.out_source  = m_tdata[115:113];
        got.last        = m_tlast;
        if (status_q.size() == 0) begin
          $error("result transaction with no status pending");
          mismatches++;
        end else begin
          want = status_q.pop_front();
          check_field("notice_kind", 64'(want.notice_kind), 64'(got.notice_kind));
          check_field("lease_state", 64'(want.lease_state), 64'(got.lease_state));
          check_field("reason", 64'(want.reason), 64'(got.reason));
          check_field("detail", 64'(want.detail), 64'(got.detail));
          check_field("out_session", want.out_session, got.out_session);
          check_field("out_ttl_ms", 64'(want.out_ttl_ms), 64'(got.out_ttl_ms));
          check_field("out_peer", 64'(want.out_peer), 64'(got.out_peer));
          check_field("out_source", 64'(want.out_source), 64'(got.out_source));
          check_field("last", 64'(want.last), 64'(got.last));
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_tready <= 1'b0;
      end else if (!no_idle() && $urandom_range(0, 6) == 0) begin
        recv_stall = $urandom_range(0, 12);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : run_control
    logic [63:0] pool_sess [6];
    logic [7:0]  pool_peer [6];
    logic [47:0] clock_ms;
    logic [2:0]  act;
    logic [63:0] sess;
    logic [7:0]  peer;
    logic [31:0] ttl;
    int pick;
    int who;

    // directed: expiry, preemption, holder matching, saturation, rejects, queries
    add_request(ACT_QUERY, 4'd0, 8'h00, '0, 3'd1, '0, 1'b0, 1'b1, '0, 1'b0);
    add_request(ACT_CLAIM, 4'd0, 8'h01, 64'h0123_4567_89ab_cdef, 3'd1, '0, 1'b0, 1'b1,
                '0, 1'b0);
    add_request(ACT_QUERY, 4'd0, 8'h01, '0, 3'd1, '0, 1'b0, 1'b1, '1, 1'b0);
    add_request(ACT_CLAIM, 4'd0, 8'h02, 64'hfedc_ba98_7654_3210, 3'd2, 32'd100, 1'b0, 1'b1,
                48'd1000, 1'b0);
    add_request(ACT_CLAIM, 4'd0, 8'h02, 64'hfedc_ba98_7654_3210, 3'd2, 32'd100, 1'b1, 1'b1,
                48'd1000, 1'b0);
    add_request(ACT_RENEW, 4'd0, 8'h01, 64'hfedc_ba98_7654_3210, 3'd2, 32'd50, 1'b0, 1'b1,
                48'd1050, 1'b0);
    add_request(ACT_RENEW, 4'd0, 8'h02, 64'hfedc_ba98_7654_3210, 3'd2, 32'd50, 1'b0, 1'b1,
                48'd1050, 1'b0);
    add_request(ACT_CLAIM, 4'd0, 8'h03, 64'h5555_aaaa_5555_aaaa, SRC_UNKNOWN, 32'd7, 1'b1,
                1'b1, 48'd1060, 1'b0);
    add_request(ACT_CLAIM, 4'd0, 8'h03, 64'h5555_aaaa_5555_aaaa, 3'd3, 32'd7, 1'b1, 1'b0,
                48'd1060, 1'b0);
    add_request(ACT_QUERY, 4'd0, 8'h03, 64'h5555_aaaa_5555_aaaa, SRC_UNKNOWN, 32'd7, 1'b0,
                1'b0, 48'd1100, 1'b0);
    add_request(ACT_PREEMPT, 4'd0, 8'h03, 64'h5555_aaaa_5555_aaaa, 3'd3, 32'd10, 1'b0, 1'b1,
                48'd1100, 1'b0);
    add_request(ACT_RELEASE, 4'd0, 8'h03, 64'h5555_aaaa_5555_aaaa, 3'd3, 32'd10, 1'b0, 1'b1,
                48'd1200, 1'b1);
    add_request(ACT_RELEASE, 4'd0, 8'h03, 64'h5555_aaaa_5555_aaaa, 3'd3, 32'd10, 1'b0, 1'b1,
                48'd1200, 1'b0);
    add_request(ACT_CLAIM, 4'd15, 8'hff, '1, 3'd7, '1, 1'b1, 1'b1, 48'hffff_ffff_fffa, 1'b0);
    add_request(ACT_QUERY, 4'd15, 8'h00, '0, 3'd7, '0, 1'b0, 1'b1, '1, 1'b0);
    add_request(ACT_RENEW, 4'd15, 8'hff, '1, 3'd7, 32'h8000_0000, 1'b0, 1'b1, '1, 1'b0);
    add_request(ACT_CLAIM, 4'd15, 8'hff, '1, 3'd7, 32'd9, 1'b0, 1'b1, '1, 1'b0);
    add_request(ACT_RELEASE, 4'd15, 8'hff, '1, 3'd7, 32'd9, 1'b0, 1'b1, '1, 1'b0);
    add_request(ACT_QUERY + 3'd1, 4'd15, 8'h00, '0, 3'd1, '0, 1'b0, 1'b1, '1, 1'b0);
    add_request(ACT_CLAIM, 4'd5, 8'h01, 64'h0123_4567_89ab_cdef, 3'd4, 32'd20, 1'b0, 1'b1,
                48'd5000, 1'b0);
    add_request(ACT_CLAIM, 4'd5, 8'h02, 64'h0123_4567_89ab_cdef, 3'd4, 32'd20, 1'b0, 1'b1,
                48'd5000, 1'b0);
    add_request(ACT_QUERY + 3'd3, 4'd5, 8'h00, '0, 3'd1, '0, 1'b0, 1'b1, 48'd5000, 1'b0);
    add_request(ACT_QUERY + 3'd2, 4'd5, 8'h00, '0, 3'd1, '0, 1'b0, 1'b1, 48'd6000, 1'b0);
    add_request(ACT_RENEW, 4'd5, 8'h01, 64'h0123_4567_89ab_cdef, 3'd4, 32'd20, 1'b0, 1'b1,
                48'd6000, 1'b0);

    // random traffic from a small set of requesters so that holders recur
    for (int i = 0; i < 6; i++) begin
      pool_sess[i] = {$urandom, $urandom};
      pool_peer[i] = 8'($urandom_range(0, 255));
    end
    pool_sess[1] = pool_sess[0];
    clock_ms = 48'd10000;
    for (int i = 0; i < 1250; i++) begin
      clock_ms += $urandom_range(0, 40);
      if ($urandom_range(0, 99) == 0)
        clock_ms = 48'({$urandom, $urandom});
      pick = $urandom_range(0, 99);
      if (pick < 35)
        act = ACT_CLAIM;
      else if (pick < 47)
        act = ACT_PREEMPT;
      else if (pick < 67)
        act = ACT_RENEW;
      else if (pick < 82)
        act = ACT_RELEASE;
      else if (pick < 96)
        act = ACT_QUERY;
      else
        act = ACT_QUERY + 3'($urandom_range(1, 3));
      who = $urandom_range(0, 5);
      sess = pool_sess[who];
      peer = pool_peer[who];
      if ($urandom_range(0, 9) == 0) begin
        sess = {$urandom, $urandom};
        peer = 8'($urandom_range(0, 255));
      end
      case ($urandom_range(0, 9))
        0: ttl = '0;
        1: ttl = $urandom;
        default: ttl = $urandom_range(1, 300);
      endcase
      add_request(act,
                  $urandom_range(0, 3) == 0 ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(0, 3)),
                  peer, sess,
                  $urandom_range(0, 24) == 0 ? SRC_UNKNOWN : 3'($urandom_range(1, 7)),
                  ttl, $urandom_range(0, 3) == 0, $urandom_range(0, 24) != 0, clock_ms,
                  i % 250 == 249);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (request_q.size() > 0 || s_tvalid || status_q.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && status_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : watchdog
    #6_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/cla_pkg.sv
rtl/core/cla_mem.sv
rtl/core/cla_outq.sv
rtl/core/control_lease_arbiter.sv
rtl/core/cla_checker.sv
bench/testbench.sv
